/* rtl/bcdasc_pkg.sv */
package bcdasc_pkg;

  localparam int DIGIT_W        = 4;
  localparam int MAX_DIGITS     = 16;
  localparam int WORD_W         = DIGIT_W * MAX_DIGITS;
  localparam int NUM_DIGITS_DEF = 16;

  localparam logic [DIGIT_W:0] DIGIT_MAX = 5'd9;
  localparam logic [DIGIT_W:0] RADIX     = 5'd10;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_SUB = 1'b1;

  typedef struct packed {
    logic              command;
    logic [WORD_W-1:0] operand_a;
    logic [WORD_W-1:0] operand_b;
  } bcd_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_digits;
    logic              negative;
    logic              carry_out;
    logic              a_less;
    logic              a_equal;
    logic              bad_digit;
  } bcd_out_t;

  // Partial work handed from one digit cell to the next.
  typedef struct packed {
    logic              command;
    logic [WORD_W-1:0] operand_a;
    logic [WORD_W-1:0] operand_b;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] diff_ab;
    logic [WORD_W-1:0] diff_ba;
    logic              carry;
    logic              borrow_ab;
    logic              borrow_ba;
    logic              lt;
    logic              gt;
    logic              bad;
  } bcd_stage_t;

  function automatic logic all_digits_ok(input logic [WORD_W-1:0] word);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if ({1'b0, word[DIGIT_W*i +: DIGIT_W]} > DIGIT_MAX) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

/* rtl/bcd_add_sub_compare_unit.sv */
// Packed-BCD add / subtract / compare, one digit cell per pipeline stage.
// Throughput: one operand pair per cycle while the output is not stalled; each cell
// works one digit of every item in flight.
// Bubbles collapse: an empty stage takes new work even while the output stalls.
// Reset (rst_n low, synchronous) empties all stages; no other state is kept.
module bcd_add_sub_compare_unit #(
  parameter int NUM_DIGITS = bcdasc_pkg::NUM_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bcdasc_pkg::bcd_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bcdasc_pkg::bcd_out_t out_data
);
  import bcdasc_pkg::*;

  bcd_stage_t st    [NUM_DIGITS+1];
  logic       valid [NUM_DIGITS+1];
  logic       ready [NUM_DIGITS+1];
  bcd_stage_t last;

  always_comb begin
    st[0]           = '0;
    st[0].command   = in_data.command;
    st[0].operand_a = in_data.operand_a;
    st[0].operand_b = in_data.operand_b;
  end

  assign valid[0]          = in_valid;
  assign in_ready          = ready[0];
  assign out_valid         = valid[NUM_DIGITS];
  assign ready[NUM_DIGITS] = out_ready;

  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
    bcdasc_cell #(
      .DIGIT_IDX(k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid[k]),
      .up_ready (ready[k]),
      .up_st    (st[k]),
      .dn_valid (valid[k+1]),
      .dn_ready (ready[k+1]),
      .dn_st    (st[k+1])
    );
  end

  always_comb begin
    last = st[NUM_DIGITS];
    if (last.command == CMD_SUB) begin
      out_data.result_digits = last.lt ? last.diff_ba : last.diff_ab;
    end else begin
      out_data.result_digits = last.sum;
    end
    out_data.negative  = (last.command == CMD_SUB) && last.lt;
    out_data.carry_out = (last.command == CMD_ADD) && last.carry;
    out_data.a_less    = last.lt;
    out_data.a_equal   = !last.lt && !last.gt;
    out_data.bad_digit = last.bad;
  end

  a_cmp_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.a_less && out_data.a_equal))
    else $error("a_less and a_equal both set");

  a_neg_means_less: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.negative |-> out_data.a_less && !out_data.carry_out)
    else $error("negative result without a less than b");

  a_result_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> all_digits_ok(out_data.result_digits))
    else $error("result holds a digit above nine");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off while the pipeline can advance");

endmodule

/* rtl/bcdasc_cell.sv */
module bcdasc_cell #(
  parameter int DIGIT_IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  bcdasc_pkg::bcd_stage_t up_st,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output bcdasc_pkg::bcd_stage_t dn_st
);
  import bcdasc_pkg::*;

  localparam int LSB = DIGIT_W * DIGIT_IDX;

  logic               valid_r, valid_nxt;
  bcd_stage_t         st_r, st_nxt;
  logic [DIGIT_W-1:0] raw_a, raw_b, da, db;
  logic               bad_a, bad_b;
  logic [DIGIT_W:0]   s_wide, sub_ab, sub_ba, d_ab, d_ba;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_st    = st_r;

  always_comb begin
    raw_a  = up_st.operand_a[LSB +: DIGIT_W];
    raw_b  = up_st.operand_b[LSB +: DIGIT_W];
    bad_a  = {1'b0, raw_a} > DIGIT_MAX;
    bad_b  = {1'b0, raw_b} > DIGIT_MAX;
    // Drop invalid digits to zero.
    da     = bad_a ? '0 : raw_a;
    db     = bad_b ? '0 : raw_b;
    st_nxt = up_st;
    st_nxt.bad = up_st.bad || bad_a || bad_b;

    s_wide = {1'b0, da} + {1'b0, db} + {{DIGIT_W{1'b0}}, up_st.carry};
    if (s_wide > DIGIT_MAX) begin
      s_wide       = s_wide - RADIX;
      st_nxt.carry = 1'b1;
    end else begin
      st_nxt.carry = 1'b0;
    end
    st_nxt.sum[LSB +: DIGIT_W] = s_wide[DIGIT_W-1:0];

    sub_ab = {1'b0, db} + {{DIGIT_W{1'b0}}, up_st.borrow_ab};
    if ({1'b0, da} < sub_ab) begin
      d_ab             = {1'b0, da} + RADIX - sub_ab;
      st_nxt.borrow_ab = 1'b1;
    end else begin
      d_ab             = {1'b0, da} - sub_ab;
      st_nxt.borrow_ab = 1'b0;
    end
    st_nxt.diff_ab[LSB +: DIGIT_W] = d_ab[DIGIT_W-1:0];

    sub_ba = {1'b0, da} + {{DIGIT_W{1'b0}}, up_st.borrow_ba};
    if ({1'b0, db} < sub_ba) begin
      d_ba             = {1'b0, db} + RADIX - sub_ba;
      st_nxt.borrow_ba = 1'b1;
    end else begin
      d_ba             = {1'b0, db} - sub_ba;
      st_nxt.borrow_ba = 1'b0;
    end
    st_nxt.diff_ba[LSB +: DIGIT_W] = d_ba[DIGIT_W-1:0];

    // Higher digits override the compare verdict of lower ones.
    if (da < db) begin
      st_nxt.lt = 1'b1;
      st_nxt.gt = 1'b0;
    end else if (da > db) begin
      st_nxt.lt = 1'b0;
      st_nxt.gt = 1'b1;
    end
  end

  always_comb begin
    valid_nxt = up_ready ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      st_r <= st_nxt;
    end
  end

endmodule

/* tb/sv/tb_bcd_add_sub_compare_unit.sv */
module tb_bcd_add_sub_compare_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bcdasc_pkg::*;

  localparam int NDIG = NUM_DIGITS_DEF;
  localparam int HANG_LIMIT = 1000;
  localparam logic [WORD_W-1:0] ALL_NINES = {MAX_DIGITS{4'h9}};
  localparam logic [WORD_W-1:0] ONE = 64'd1;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  bcd_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  bcd_out_t out_data;

  bcd_out_t bcd_result_q[$];

  int gap_pct;
  int stall_pct;
  int fail_count;
  int checked_count;
  int idle_cycles;
  int add_count;
  int sub_count;
  int bad_count;
  int carry_count;
  int neg_count;
  int equal_count;

  bcd_add_sub_compare_unit #(
    .NUM_DIGITS(NDIG)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Digits above 9 count as zero everywhere; the flag records that it happened.
  function automatic bcd_out_t bcd_arith_predict(bcd_in_t item);
    int       da[MAX_DIGITS];
    int       db[MAX_DIGITS];
    int       order;
    int       cy;
    int       borrow;
    int       s;
    int       hi;
    int       lo;
    bcd_out_t res;
    res    = '0;
    order  = 0;
    cy     = 0;
    borrow = 0;
    for (int i = 0; i < NDIG; i++) begin
      da[i] = item.operand_a[DIGIT_W*i +: DIGIT_W];
      db[i] = item.operand_b[DIGIT_W*i +: DIGIT_W];
      if (da[i] > DIGIT_MAX) begin
        da[i] = 0;
        res.bad_digit = 1'b1;
      end
      if (db[i] > DIGIT_MAX) begin
        db[i] = 0;
        res.bad_digit = 1'b1;
      end
    end
    for (int i = NDIG - 1; i >= 0 && order == 0; i--) begin
      if (da[i] < db[i]) order = -1;
      else if (da[i] > db[i]) order = 1;
    end
    res.a_less  = (order < 0);
    res.a_equal = (order == 0);
    if (item.command == CMD_ADD) begin
      for (int i = 0; i < NDIG; i++) begin
        s = da[i] + db[i] + cy;
        if (s > DIGIT_MAX) begin
          s  = s - RADIX;
          cy = 1;
        end else begin
          cy = 0;
        end
        res.result_digits[DIGIT_W*i +: DIGIT_W] = DIGIT_W'(s);
      end
      res.carry_out = (cy != 0);
    end else begin
      // subtract the smaller magnitude from the larger one
      res.negative = (order < 0);
      for (int i = 0; i < NDIG; i++) begin
        hi = (order < 0) ? db[i] : da[i];
        lo = ((order < 0) ? da[i] : db[i]) + borrow;
        if (hi < lo) begin
          s      = hi + RADIX - lo;
          borrow = 1;
        end else begin
          s      = hi - lo;
          borrow = 0;
        end
        res.result_digits[DIGIT_W*i +: DIGIT_W] = DIGIT_W'(s);
      end
    end
    return res;
  endfunction

  // Mostly clean BCD; some words are short, a few carry one invalid nibble.
  function automatic logic [WORD_W-1:0] rand_bcd_word(int bad_pct);
    logic [WORD_W-1:0] w;
    int                len;
    w   = '0;
    len = ($urandom_range(3) == 0) ? $urandom_range(MAX_DIGITS, 1) : MAX_DIGITS;
    for (int i = 0; i < len; i++) begin
      w[DIGIT_W*i +: DIGIT_W] = DIGIT_W'($urandom_range(9));
    end
    if ($urandom_range(99) < bad_pct) begin
      w[DIGIT_W*$urandom_range(MAX_DIGITS-1) +: DIGIT_W] = DIGIT_W'($urandom_range(15, 10));
    end
    return w;
  endfunction

  task automatic send_operands(input logic cmd, input logic [WORD_W-1:0] a,
                               input logic [WORD_W-1:0] b);
    bcd_in_t  item;
    bcd_out_t want;
    item.command   = cmd;
    item.operand_a = a;
    item.operand_b = b;
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    want = bcd_arith_predict(item);
    bcd_result_q.push_back(want);
    if (cmd == CMD_ADD) add_count++;
    else sub_count++;
    if (want.bad_digit) bad_count++;
    if (want.carry_out) carry_count++;
    if (want.negative) neg_count++;
    if (want.a_equal) equal_count++;
  endtask

  // Hold the input idle until every pending result has come back.
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (bcd_result_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_digit_extremes();
    send_operands(CMD_ADD, '0, '0);
    send_operands(CMD_ADD, ALL_NINES, ALL_NINES);
    send_operands(CMD_ADD, ALL_NINES, ONE);
    send_operands(CMD_ADD, 64'h5000_0000_0000_0000, 64'h5000_0000_0000_0000);
    send_operands(CMD_SUB, '0, '0);
    send_operands(CMD_SUB, '0, ALL_NINES);
    send_operands(CMD_SUB, ALL_NINES, '0);
    send_operands(CMD_SUB, ALL_NINES, ALL_NINES);
  endtask

  task automatic test_carry_and_borrow();
    send_operands(CMD_ADD, 64'h0000_0000_0999_9999, ONE);
    send_operands(CMD_ADD, 64'h1234_5678_9012_3456, 64'h8765_4321_0987_6543);
    send_operands(CMD_SUB, 64'h1000_0000_0000_0000, ONE);
    send_operands(CMD_SUB, ONE, 64'h1000_0000_0000_0000);
    send_operands(CMD_SUB, 64'h1234_5678_9012_3456, 64'h1234_5678_9012_3457);
    send_operands(CMD_SUB, 64'h8642_0975_3186_4209, 64'h8642_0975_3186_4209);
  endtask

  task automatic test_invalid_digits();
    send_operands(CMD_ADD, {MAX_DIGITS{4'hF}}, '0);
    send_operands(CMD_SUB, 64'h0000_0000_0000_000A, '0);
    send_operands(CMD_SUB, 64'hF000_0000_0000_0000, ONE);
    send_operands(CMD_ADD, 64'h0000_0000_0000_00B9, ONE);
    send_operands(CMD_SUB, 64'hABCD_EF00_0000_0000, 64'h9999_9999_9999_999E);
    send_operands(CMD_ADD, 64'h9999_9999_9999_9999, 64'hC000_0000_0000_0001);
  endtask

  task automatic test_random_traffic(input int count, input int send_gap,
                                     input int recv_stall);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    int                sel;
    int                idx;
    gap_pct   = send_gap;
    stall_pct = recv_stall;
    for (int n = 0; n < count; n++) begin
      a   = rand_bcd_word(6);
      b   = rand_bcd_word(6);
      sel = $urandom_range(99);
      if (sel < 15) begin
        b = a;
      end else if (sel < 35) begin
        // differ in one digit at most, so the compare has to look deep
        b   = a;
        idx = $urandom_range(NDIG - 1);
        b[DIGIT_W*idx +: DIGIT_W] = DIGIT_W'($urandom_range(9));
      end else if (sel < 50) begin
        // nines complement drives long carry chains
        for (int i = 0; i < MAX_DIGITS; i++) begin
          b[DIGIT_W*i +: DIGIT_W] = 4'd9 - a[DIGIT_W*i +: DIGIT_W];
        end
        if ($urandom_range(1)) b = b + ONE;
      end else if (sel < 55) begin
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
      end
      send_operands($urandom_range(1) ? CMD_SUB : CMD_ADD, a, b);
      if (n == count / 2) hold_until_drained();
    end
    hold_until_drained();
  endtask

  always @(posedge clk) begin : result_check
    bcd_out_t want;
    string    diffs;
    if (rst_n && out_valid && out_ready) begin
      if (bcd_result_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("%0t: result with nothing pending: %p", $realtime, out_data);
      end else begin
        want  = bcd_result_q.pop_front();
        diffs = "";
        checked_count++;
        if (out_data.result_digits !== want.result_digits) diffs = {diffs, " result_digits"};
        if (out_data.negative !== want.negative) diffs = {diffs, " negative"};
        if (out_data.carry_out !== want.carry_out) diffs = {diffs, " carry_out"};
        if (out_data.a_less !== want.a_less) diffs = {diffs, " a_less"};
        if (out_data.a_equal !== want.a_equal) diffs = {diffs, " a_equal"};
        if (out_data.bad_digit !== want.bad_digit) diffs = {diffs, " bad_digit"};
        if (diffs != "") begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: mismatch in%s", $realtime, diffs);
            $display("  expected %p", want);
            $display("  actual   %p", out_data);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("tb_bcd_add_sub_compare_unit: errors");
      $finish;
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    gap_pct       = 0;
    stall_pct     = 0;
    fail_count    = 0;
    checked_count = 0;
    idle_cycles   = 0;
    add_count     = 0;
    sub_count     = 0;
    bad_count     = 0;
    carry_count   = 0;
    neg_count     = 0;
    equal_count   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_digit_extremes();
    test_carry_and_borrow();
    test_invalid_digits();
    hold_until_drained();
    test_random_traffic(250, 0, 0);
    test_random_traffic(250, 51, 0);
    test_random_traffic(250, 0, 51);
    test_random_traffic(250, 18, 18);
    test_random_traffic(250, 0, 0);

    // let any stray result surface
    repeat (NDIG + 4) @(posedge clk);
    if (bcd_result_q.size() != 0) begin
      fail_count += bcd_result_q.size();
      $display("%0d results never arrived", bcd_result_q.size());
    end

    $display("%0d operand pairs: %0d add, %0d subtract, %0d with invalid digits, %0d equal",
             add_count + sub_count, add_count, sub_count, bad_count, equal_count);
    $display("%0d carries out, %0d negative differences, %0d results checked",
             carry_count, neg_count, checked_count);
    if (fail_count == 0) begin
      $display("tb_bcd_add_sub_compare_unit: clean");
    end else begin
      $display("tb_bcd_add_sub_compare_unit: errors");
    end
    $finish;
  end

endmodule
